// ===== src/ttce_pkg.sv =====
// Shared types, codes and constants for the text terminal cursor engine.
package ttce_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] ATTR     = 8'h0F;

    localparam int TAB_STEP = 8;
    localparam int TAB_MASK = 7;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } ttce_in_t;

    typedef struct packed {
        logic [ROW_W-1:0] cursor_row_out;
        logic [COL_W-1:0] cursor_col_out;
        logic [15:0]      cell_word;
        logic             scrolled;
    } ttce_out_t;

    // Logical cell position, mapped to a memory address by the address unit.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } ttce_cell_t;

    // Write request toward the screen memory.
    typedef struct packed {
        logic              we;
        logic [CHAR_W-1:0] wdata;
    } ttce_mem_req_t;

endpackage

// ===== src/ttce_addr_unit.sv =====
// Shared address unit: logical cell plus ring row base to screen memory address.
module ttce_addr_unit #(
    parameter int COLUMNS = ttce_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttce_pkg::DEF_ROWS,
    parameter int ADDR_W  = $clog2(ROWS * COLUMNS)
) (
    input  ttce_pkg::ttce_cell_t            pos,
    input  logic [ttce_pkg::ROW_W-1:0]      base,
    output logic [ADDR_W-1:0]               addr
);
    import ttce_pkg::*;

    logic [ROW_W:0]   row_sum;
    logic [ROW_W-1:0] phys_row;

    // Rows live in a ring; wrap the rotated row once since both terms stay below ROWS.
    always_comb
    begin
        row_sum = {1'b0, pos.row} + {1'b0, base};
        if (row_sum >= (ROW_W + 1)'(ROWS))
        begin
            row_sum = row_sum - (ROW_W + 1)'(ROWS);
        end
        phys_row = row_sum[ROW_W-1:0];
    end

    assign addr = ADDR_W'(ADDR_W'(phys_row) * ADDR_W'(COLUMNS)) + ADDR_W'(pos.col);

endmodule

// ===== src/ttce_screen_mem.sv =====
// Screen character memory: one port, registered read.
module ttce_screen_mem #(
    parameter int DEPTH  = ttce_pkg::DEF_ROWS * ttce_pkg::DEF_COLUMNS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic [ADDR_W-1:0]            addr,
    input  ttce_pkg::ttce_mem_req_t      req,
    output logic [ttce_pkg::CHAR_W-1:0]  rdata
);
    import ttce_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[addr] <= req.wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/text_terminal_cursor_engine_unit.sv =====
// Top level of the text terminal cursor engine: sequencer, cursor and result register.
//
//  channel | handshake          | payload            | direction
//  --------+--------------------+--------------------+----------
//  command | start / busy       | cmd    (ttce_in_t) | in
//  result  | done (1-cycle)     | result (ttce_out_t)| out
//
// A word is taken at an edge with start high and busy low. Put (other than a scroll),
// out-of-range read and unused ops report straight from idle; an in-range read passes
// through the read state (registered memory read); a put that scrolls walks the bottom
// row blank over the single memory port; clear walks every cell of the screen.
// After reset the block runs a clearing pass over every cell with busy high.
// Each result shows on result with done, high for exactly one cycle; the receiver cannot stall.
// Scrolling rotates a ring row base, so no row copy is needed.
module text_terminal_cursor_engine_unit #(
    parameter int COLUMNS = ttce_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttce_pkg::DEF_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ttce_pkg::ttce_in_t   cmd,
    output logic                 done,
    output ttce_pkg::ttce_out_t  result
);
    import ttce_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_BLANK = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    logic [1:0]       state_reg,  state_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] base_reg,   base_next;
    logic [ROW_W-1:0] sw_row_reg, sw_row_next;
    logic [COL_W-1:0] sw_col_reg, sw_col_next;
    logic             report_reg, report_next;
    logic             scroll_reg, scroll_next;
    logic             done_reg,   done_next;
    ttce_out_t        result_reg, result_next;

    ttce_cell_t        acc_cell;
    ttce_mem_req_t     mem_req;
    logic [ADDR_W-1:0] mem_addr;
    logic [CHAR_W-1:0] mem_rdata;

    logic              accept;
    logic              read_ok;

    // Put-character decode results.
    logic [ROW_W:0]    p_row;
    logic [COL_W:0]    p_col;
    logic              p_we;
    ttce_cell_t        p_cell;
    logic [CHAR_W-1:0] p_data;
    logic              p_scroll;
    logic [ROW_W-1:0]  p_row_fin;

    ttce_addr_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_addr (
        .pos  (acc_cell),
        .base (base_reg),
        .addr (mem_addr)
    );

    ttce_screen_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .addr  (mem_addr),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign accept  = start && (state_reg == ST_IDLE);
    assign read_ok = ({1'b0, cmd.read_row} < (ROW_W + 1)'(ROWS))
                  && ({1'b0, cmd.read_col} < (COL_W + 1)'(COLUMNS));

    // Cursor motion and cell write for a put word.
    always_comb
    begin
        p_row      = {1'b0, cur_row_reg};
        p_col      = {1'b0, cur_col_reg};
        p_we       = 1'b0;
        p_cell.row = cur_row_reg;
        p_cell.col = cur_col_reg;
        p_data     = cmd.char_code;
        case (cmd.char_code)
            CH_NL:
            begin
                p_col = '0;
                p_row = p_row + 1'b1;
            end
            CH_CR:
            begin
                p_col = '0;
            end
            CH_TAB:
            begin
                p_col = (p_col + (COL_W + 1)'(TAB_STEP)) & ~((COL_W + 1)'(TAB_MASK));
            end
            CH_BS:
            begin
                p_data = CH_BLANK;
                if (cur_col_reg != '0)
                begin
                    p_col      = p_col - 1'b1;
                    p_we       = 1'b1;
                    p_cell.col = cur_col_reg - 1'b1;
                end
                else if (cur_row_reg != '0)
                begin
                    p_row      = p_row - 1'b1;
                    p_col      = {1'b0, LAST_COL};
                    p_we       = 1'b1;
                    p_cell.row = cur_row_reg - 1'b1;
                    p_cell.col = LAST_COL;
                end
            end
            default:
            begin
                p_we  = 1'b1;
                p_col = p_col + 1'b1;
            end
        endcase
        // Wrap past the last column.
        if (p_col >= (COL_W + 1)'(COLUMNS))
        begin
            p_col = '0;
            p_row = p_row + 1'b1;
        end
        p_scroll  = (p_row >= (ROW_W + 1)'(ROWS));
        p_row_fin = p_scroll ? LAST_ROW : p_row[ROW_W-1:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        base_next    = base_reg;
        sw_row_next  = sw_row_reg;
        sw_col_next  = sw_col_reg;
        report_next  = report_reg;
        scroll_next  = scroll_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_req.we    = 1'b0;
        mem_req.wdata = CH_BLANK;
        acc_cell.row  = sw_row_reg;
        acc_cell.col  = sw_col_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.op == OP_READ)
                begin
                    acc_cell.row = cmd.read_row;
                    acc_cell.col = cmd.read_col;
                end
                else
                begin
                    acc_cell = p_cell;
                end
                if (accept)
                begin
                    result_next.cursor_row_out = cur_row_reg;
                    result_next.cursor_col_out = cur_col_reg;
                    result_next.cell_word      = '0;
                    result_next.scrolled       = 1'b0;
                    case (cmd.op)
                        OP_PUT:
                        begin
                            mem_req.we    = p_we;
                            mem_req.wdata = p_data;
                            cur_row_next  = p_row_fin;
                            cur_col_next  = p_col[COL_W-1:0];
                            if (p_scroll)
                            begin
                                // Rotate the ring; the old top row becomes the bottom row.
                                base_next   = (base_reg == LAST_ROW) ? '0 : base_reg + 1'b1;
                                sw_row_next = LAST_ROW;
                                sw_col_next = '0;
                                report_next = 1'b1;
                                scroll_next = 1'b1;
                                state_next  = ST_BLANK;
                            end
                            else
                            begin
                                result_next.cursor_row_out = p_row_fin;
                                result_next.cursor_col_out = p_col[COL_W-1:0];
                                done_next = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (read_ok)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cur_row_next = '0;
                            cur_col_next = '0;
                            base_next    = '0;
                            sw_row_next  = '0;
                            sw_col_next  = '0;
                            report_next  = 1'b1;
                            scroll_next  = 1'b0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                result_next.cursor_row_out = cur_row_reg;
                result_next.cursor_col_out = cur_col_reg;
                result_next.cell_word      = {ATTR, mem_rdata};
                result_next.scrolled       = 1'b0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                // Blank walk: one cell a cycle, bottom row only or the whole screen.
                mem_req.we = 1'b1;
                if (sw_col_reg == LAST_COL)
                begin
                    sw_col_next = '0;
                    if ((state_reg == ST_BLANK) || (sw_row_reg == LAST_ROW))
                    begin
                        state_next = ST_IDLE;
                        if (report_reg)
                        begin
                            result_next.cursor_row_out = cur_row_reg;
                            result_next.cursor_col_out = cur_col_reg;
                            result_next.cell_word      = '0;
                            result_next.scrolled       = scroll_reg;
                            done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        sw_row_next = sw_row_reg + 1'b1;
                    end
                end
                else
                begin
                    sw_col_next = sw_col_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            base_reg    <= '0;
            sw_row_reg  <= '0;
            sw_col_reg  <= '0;
            report_reg  <= 1'b0;
            scroll_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            base_reg    <= base_next;
            sw_row_reg  <= sw_row_next;
            sw_col_reg  <= sw_col_next;
            report_reg  <= report_next;
            scroll_reg  <= scroll_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // After the read state, which waits for the memory, the read reports in the next cycle.
    a_read_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> done_reg)
        else $error("read did not report");

    // A scroll always leaves the cursor on the bottom row.
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.scrolled) |-> (result_reg.cursor_row_out == LAST_ROW))
        else $error("scroll left cursor off bottom row");

    // The cursor stays on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg <= LAST_ROW) && (cur_col_reg <= LAST_COL))
        else $error("cursor off screen");

    // A clear starts its walk at the home cell.
    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == OP_CLEAR)) |=>
            ((state_reg == ST_CLEAR) && (sw_row_reg == '0) && (sw_col_reg == '0)))
        else $error("clear walk did not start at home");

endmodule

// ===== tb/cursor_report_checker.sv =====
// Checker for the text terminal cursor engine: shadow screen, cursor prediction and report compare.
module cursor_report_checker #(
    parameter int COLUMNS = ttce_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttce_pkg::DEF_ROWS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  ttce_pkg::ttce_in_t  cmd,
    input  logic                done,
    input  ttce_pkg::ttce_out_t result,
    output int                  mismatch_count,
    output int                  reports_owed
);
    import ttce_pkg::*;

    logic [CHAR_W-1:0] screen_copy [ROWS][COLUMNS];
    int                cur_row;
    int                cur_col;
    ttce_out_t         owed_reports [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            mismatch_count++;
            $display("%0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    function automatic void blank_screen();
        begin
            foreach (screen_copy[r, c])
                screen_copy[r][c] = CH_BLANK;
        end
    endfunction

    // Advance the shadow terminal by one command word and return the report it owes.
    function automatic ttce_out_t terminal_step(input ttce_in_t w);
        ttce_out_t rep;
        begin
            rep = '0;
            case (w.op)
                OP_PUT:
                begin
                    if (w.char_code == CH_NL) begin
                        cur_col = 0;
                        cur_row++;
                    end else if (w.char_code == CH_CR) begin
                        cur_col = 0;
                    end else if (w.char_code == CH_TAB) begin
                        cur_col = (cur_col + TAB_STEP) & ~TAB_MASK;
                    end else if (w.char_code == CH_BS) begin
                        if (cur_col > 0) begin
                            cur_col--;
                            screen_copy[cur_row][cur_col] = CH_BLANK;
                        end else if (cur_row > 0) begin
                            cur_row--;
                            cur_col = COLUMNS - 1;
                            screen_copy[cur_row][cur_col] = CH_BLANK;
                        end
                    end else begin
                        screen_copy[cur_row][cur_col] = w.char_code;
                        cur_col++;
                    end
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                    // Shift every line up, blank the bottom one, park the cursor there.
                    if (cur_row >= ROWS) begin
                        for (int r = 0; r < ROWS - 1; r++)
                            for (int c = 0; c < COLUMNS; c++)
                                screen_copy[r][c] = screen_copy[r + 1][c];
                        for (int c = 0; c < COLUMNS; c++)
                            screen_copy[ROWS - 1][c] = CH_BLANK;
                        cur_row      = ROWS - 1;
                        rep.scrolled = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (w.read_row < ROWS && w.read_col < COLUMNS)
                        rep.cell_word = {ATTR, screen_copy[w.read_row][w.read_col]};
                end
                OP_CLEAR:
                begin
                    blank_screen();
                    cur_row = 0;
                    cur_col = 0;
                end
                default:
                begin
                end
            endcase
            rep.cursor_row_out = cur_row[ROW_W-1:0];
            rep.cursor_col_out = cur_col[COL_W-1:0];
            return rep;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ttce_out_t want;
        if (!rst_n) begin
            blank_screen();
            cur_row        = 0;
            cur_col        = 0;
            owed_reports.delete();
            mismatch_count = 0;
            reports_owed   = 0;
        end else begin
            if (done) begin
                if (owed_reports.size() == 0) begin
                    report_mismatch("report with nothing owed:", int'(result), 0);
                end else begin
                    want = owed_reports.pop_front();
                    if (result.cursor_row_out !== want.cursor_row_out)
                        report_mismatch("cursor_row_out", int'(result.cursor_row_out),
                                        int'(want.cursor_row_out));
                    if (result.cursor_col_out !== want.cursor_col_out)
                        report_mismatch("cursor_col_out", int'(result.cursor_col_out),
                                        int'(want.cursor_col_out));
                    if (result.cell_word !== want.cell_word)
                        report_mismatch("cell_word", int'(result.cell_word),
                                        int'(want.cell_word));
                    if (result.scrolled !== want.scrolled)
                        report_mismatch("scrolled", int'(result.scrolled),
                                        int'(want.scrolled));
                end
            end
            if (start && !busy)
                owed_reports.push_back(terminal_step(cmd));
            reports_owed = owed_reports.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the text terminal cursor engine testbench: clock, reset, command stimulus and verdict.
module testbench;
    import ttce_pkg::*;

    // The block decodes op 3 as a no-op that only reports the cursor.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Longest legal quiet stretch is a full clear walk or the clearing pass after reset;
    // allow many times that before calling it a hang.
    localparam int QUIET_LIMIT  = 20000;
    // Random command words after the directed opening.
    localparam int RANDOM_WORDS = 930;
    // Settle time at the end: well past a scroll's bottom-row walk.
    localparam int DRAIN_CYCLES = 200;

    // Character mixes that steer the random part into different corners.
    typedef enum int {
        MIX_TEXT,   // ordinary typing with the odd control byte
        MIX_ERASE,  // runs of backspace, crossing back over line starts
        MIX_READ,   // mostly cell reads
        MIX_LINES   // mostly newlines, to reach the bottom row and scroll
    } text_mix_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    ttce_in_t  cmd   = '0;
    logic      done;
    ttce_out_t result;

    int mismatch_count;
    int reports_owed;
    int quiet_cycles;

    always #5 clk = ~clk;

    text_terminal_cursor_engine_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    cursor_report_checker watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .done           (done),
        .result         (result),
        .mismatch_count (mismatch_count),
        .reports_owed   (reports_owed)
    );

    // Watchdog: count cycles where no word moves on either side; drop the run on a hang.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((start && !busy) || done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("text_terminal_cursor_engine_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Word builders: fill unused fields with junk, so the block must ignore them.
    function automatic ttce_in_t put_word(input logic [CHAR_W-1:0] ch);
        ttce_in_t w;
        begin
            w           = ttce_in_t'($urandom);
            w.op        = OP_PUT;
            w.char_code = ch;
            return w;
        end
    endfunction

    function automatic ttce_in_t read_word(input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col);
        ttce_in_t w;
        begin
            w          = ttce_in_t'($urandom);
            w.op       = OP_READ;
            w.read_row = row;
            w.read_col = col;
            return w;
        end
    endfunction

    function automatic ttce_in_t bare_word(input logic [1:0] op);
        ttce_in_t w;
        begin
            w    = ttce_in_t'($urandom);
            w.op = op;
            return w;
        end
    endfunction

    // Mostly in-range cells; the rest spread over the whole field range, so
    // rows past the bottom and columns past the right edge show up too.
    function automatic ttce_in_t random_read();
        begin
            if ($urandom_range(0, 99) < 85)
                return read_word(ROW_W'($urandom_range(0, DEF_ROWS - 1)),
                                 COL_W'($urandom_range(0, DEF_COLUMNS - 1)));
            return read_word(ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
        end
    endfunction

    function automatic ttce_in_t random_word(input text_mix_t mix);
        int roll;
        begin
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_ERASE:
                begin
                    if (roll < 70)      return put_word(CH_BS);
                    else if (roll < 90) return put_word(CHAR_W'($urandom_range(0, 255)));
                    else                return random_read();
                end
                MIX_READ:
                begin
                    if (roll < 80) return random_read();
                    else           return put_word(CHAR_W'($urandom_range(0, 255)));
                end
                MIX_LINES:
                begin
                    if (roll < 60)      return put_word(CH_NL);
                    else if (roll < 90) return put_word(CHAR_W'($urandom_range(0, 255)));
                    else                return random_read();
                end
                default:
                begin
                    // Clear is rare on purpose: each one walks the whole screen.
                    if (roll < 50)      return put_word(CHAR_W'($urandom_range(0, 255)));
                    else if (roll < 62) return put_word(CH_NL);
                    else if (roll < 67) return put_word(CH_CR);
                    else if (roll < 74) return put_word(CH_TAB);
                    else if (roll < 80) return put_word(CH_BS);
                    else if (roll < 96) return random_read();
                    else if (roll < 99) return bare_word(OP_SPARE);
                    else                return bare_word(OP_CLEAR);
                end
            endcase
        end
    endfunction

    // Offer one word at the falling edge and hold it until the block takes it.
    // A word is taken at a rising edge where start is high and busy is low.
    task automatic send_word(input ttce_in_t w);
        begin
            @(negedge clk);
            start <= 1'b1;
            cmd   <= w;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    // Hold start low for the given number of cycles, with junk on the command bus.
    task automatic pause_sender(input int cycles);
        begin
            @(negedge clk);
            start <= 1'b0;
            cmd   <= ttce_in_t'($urandom);
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    initial
    begin
        text_mix_t mix;
        int        left_in_mix;
        int        burst_left;

        // Hold reset, then release it once at a falling edge.
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: the unused op, edge characters, every control byte,
        // reads at the corners and just outside them, wraps, and a clear.
        send_word(bare_word(OP_SPARE));
        send_word(put_word(CH_BS));           // backspace at home: nothing moves
        send_word(put_word(8'h00));
        send_word(put_word(8'hFF));
        send_word(put_word(CH_TAB));          // column 2 to 8
        send_word(put_word(8'h7F));
        send_word(put_word(CH_CR));
        send_word(read_word(5'd0, 7'd0));
        send_word(read_word(5'd0, 7'd1));
        send_word(read_word(ROW_W'(DEF_ROWS - 1), COL_W'(DEF_COLUMNS - 1)));
        send_word(read_word(ROW_W'(DEF_ROWS), 7'd0)); // first row past the bottom
        send_word(read_word(5'd31, 7'd127));
        send_word(read_word(5'd0, COL_W'(DEF_COLUMNS)));
        send_word(put_word(CH_NL));
        send_word(put_word(CH_BS));           // back over the line start to the last column
        send_word(put_word(8'h41));           // write in the last column, wrap to next row
        send_word(read_word(5'd0, COL_W'(DEF_COLUMNS - 1)));
        send_word(put_word(CH_BS));
        send_word(put_word(CH_TAB));          // tab from the last column wraps
        send_word(read_word(5'd0, 7'd8));
        send_word(bare_word(OP_CLEAR));
        send_word(read_word(5'd0, 7'd0));

        // Random part: mixes change every few dozen words; the sender works in
        // bursts, with a random gap before most of them and none before the rest.
        left_in_mix = 0;
        burst_left  = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (left_in_mix == 0) begin
                mix         = text_mix_t'($urandom_range(0, 3));
                left_in_mix = $urandom_range(10, 40);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(0, 9) < 7)
                    pause_sender($urandom_range(1, 12));
            end
            send_word(random_word(mix));
            left_in_mix--;
            burst_left--;
        end

        // Drop start, wait for every owed report, then let stray strobes show up.
        @(negedge clk);
        start <= 1'b0;
        wait (reports_owed == 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("text_terminal_cursor_engine_unit: match");
        else
            $display("text_terminal_cursor_engine_unit: mismatch");
        $finish;
    end

endmodule
